// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check samples on the rising edge of clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bcrp_pkg.sv
package bcrp_pkg;

  // Record phase of the catalog walk
  typedef enum logic [2:0] {
    PH_VALID,
    PH_DEFAULT,
    PH_HDR_FIRST,
    PH_HDR_NEXT,
    PH_ENTRY,
    PH_EXT
  } phase_t;

  // Record kinds on the result channel
  localparam logic [2:0] KIND_VALIDATION = 3'd0;
  localparam logic [2:0] KIND_DEFAULT    = 3'd1;
  localparam logic [2:0] KIND_HEADER     = 3'd2;
  localparam logic [2:0] KIND_ENTRY      = 3'd3;
  localparam logic [2:0] KIND_EXTENSION  = 3'd4;
  localparam logic [2:0] KIND_END        = 3'd5;

  // Error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_BAD_ID   = 3'd1;
  localparam logic [2:0] ERR_CHECKSUM = 3'd2;
  localparam logic [2:0] ERR_BOOT_IND = 3'd3;
  localparam logic [2:0] ERR_MEDIA    = 3'd4;
  localparam logic [2:0] ERR_CRITERIA = 3'd5;

  // Catalog byte values
  localparam logic [7:0] ID_VALIDATION = 8'h01;
  localparam logic [7:0] ID_HDR_MORE   = 8'h90;
  localparam logic [7:0] ID_HDR_LAST   = 8'h91;
  localparam logic [7:0] ID_EXTENSION  = 8'h44;
  localparam logic [7:0] BOOT_MARK     = 8'h88;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] CRIT_MAX      = 8'h01;
  localparam logic [3:0] MEDIA_MAX     = 4'd4;
  localparam int         EXT_MORE_BIT  = 5;
  localparam logic [15:0] SEG_DEFAULT  = 16'h07C0;

  // Record geometry
  localparam int         REC_KEPT     = 12;
  localparam int         KEPT_W       = $clog2(REC_KEPT);
  localparam logic [4:0] POS_LAST     = 5'd31;
  localparam logic [4:0] POS_ID       = 5'd0;
  localparam logic [4:0] POS_PLATFORM = 5'd1;
  localparam logic [4:0] POS_CRIT     = 5'd12;

  typedef struct packed {
    logic [7:0] catalog_byte;
    logic       start_of_catalog;
  } catalog_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [2:0]  error_code;
    logic [7:0]  platform;
    logic        bootable;
    logic [3:0]  media_type;
    logic [19:0] load_value;
    logic [15:0] sector_count;
    logic [31:0] start_block;
    logic [15:0] section_count;
    logic        last_flag;
    logic        walk_finished;
  } record_item_t;

endpackage

// File: rtl/core/bcrp_stream_if.sv
// Valid/ready channel; a transfer happens when both are high at a clock edge.
interface bcrp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/bcrp_out_buf.sv
// Two-entry result queue; keeps the byte side running while a result waits.
module bcrp_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bcrp_pkg::record_item_t push_data,
  output logic                   full,
  bcrp_stream_if.source          records
);

  logic [1:0]             count;
  bcrp_pkg::record_item_t slot_head;
  bcrp_pkg::record_item_t slot_tail;
  logic                   pop;

  assign pop           = records.valid && records.ready;
  assign records.valid = (count != 2'd0);
  assign records.data  = slot_head;
  assign full          = (count == 2'd2);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Storage; head is always the oldest result
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot_head <= push_data;
        end else begin
          slot_tail <= push_data;
        end
      end
      2'b01: begin
        slot_head <= slot_tail;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot_head <= push_data;
        end else begin
          slot_head <= slot_tail;
          slot_tail <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/boot_catalog_record_parser.sv
// Boot catalog record parser.
// catalog (sink): one catalog byte per transfer, with start_of_catalog marking
//   byte 0 of the validation entry; that restarts the walk at any point.
// records (source): one result per 32-byte record, sent with its last byte,
//   or at once for the zero byte that ends the list after the default entry.
// Throughput: one byte per cycle while catalog.ready is high. Each byte passes through a single
//   level of compare/capture/16-bit add logic into the walk state.
// Output: a result is registered into the result queue when the byte that ends
//   the record is accepted, and is sent on records once older results have left.
// Stall: results go into a two-entry queue; catalog.ready drops only while
//   both entries are held. Results are 32 bytes apart, except the end result
//   that can follow a default entry at once, so a short receiver stall never
//   slows the byte stream.
// After an error or the end of the catalog, bytes are taken and dropped
//   until the next start_of_catalog.
// Reset (rst, synchronous): the walk expects the validation entry at byte 0
//   and the result queue is emptied; no clearing pass is needed.
module boot_catalog_record_parser (
  input  logic          clk,
  input  logic          rst,
  bcrp_stream_if.sink   catalog,
  bcrp_stream_if.source records
);

  `include "assert_macros.svh"

  // Walk state
  logic [4:0]              byte_position;
  bcrp_pkg::phase_t        record_phase;
  logic [15:0]             word_sum;
  logic [7:0]              held_low_byte;
  logic [7:0]              current_platform;
  logic [15:0]             entries_left;
  logic                    last_header_seen;
  logic [2:0]              pending_error;
  logic                    finished_flag;
  logic [7:0]              record_bytes [bcrp_pkg::REC_KEPT];

  logic [4:0]              byte_position_next;
  bcrp_pkg::phase_t        record_phase_next;
  logic [15:0]             word_sum_next;
  logic [7:0]              held_low_byte_next;
  logic [7:0]              current_platform_next;
  logic [15:0]             entries_left_next;
  logic                    last_header_seen_next;
  logic [2:0]              pending_error_next;
  logic                    finished_flag_next;

  // Per-byte view
  logic                    accept;
  logic                    restart;
  logic                    active;
  logic [7:0]              b;
  logic [4:0]              e_pos;
  bcrp_pkg::phase_t        e_phase;
  logic [15:0]             e_sum;
  logic [7:0]              e_held;
  logic [7:0]              e_plat;
  logic [15:0]             e_entries;
  logic                    e_last;
  logic [2:0]              e_err;
  logic [15:0]             sum_now;
  logic                    end_mark;
  logic                    rec_done;
  logic [2:0]              err_byte;
  logic [2:0]              err_final;
  logic [2:0]              kind;

  // Record bytes kept for decode
  logic [15:0]             hdr_count;
  logic [15:0]             ent_dec;
  logic [15:0]             chain_entries;
  logic                    chain_last;
  logic                    ext_more;

  bcrp_pkg::record_item_t  res;
  logic                    res_push;
  logic                    queue_full;
  logic [15:0]             seg;

  assign accept        = catalog.valid && catalog.ready;
  assign catalog.ready = !queue_full;
  assign restart       = catalog.data.start_of_catalog;
  assign b             = catalog.data.catalog_byte;
  assign active        = accept && (restart || !finished_flag);

  // A start mark sees the reset state
  assign e_pos     = restart ? 5'd0 : byte_position;
  assign e_phase   = restart ? bcrp_pkg::PH_VALID : record_phase;
  assign e_sum     = restart ? 16'd0 : word_sum;
  assign e_held    = restart ? 8'd0 : held_low_byte;
  assign e_plat    = restart ? 8'd0 : current_platform;
  assign e_entries = restart ? 16'd0 : entries_left;
  assign e_last    = restart ? 1'b0 : last_header_seen;
  assign e_err     = restart ? bcrp_pkg::ERR_OK : pending_error;

  // Little-endian word sum, updated on the high byte
  assign sum_now  = e_pos[0] ? (e_sum + {b, e_held}) : e_sum;
  assign end_mark = (e_phase == bcrp_pkg::PH_HDR_FIRST) && (e_pos == bcrp_pkg::POS_ID)
                    && (b == bcrp_pkg::BYTE_ZERO);
  assign rec_done = (e_pos == bcrp_pkg::POS_LAST);

  // Byte checks for the current phase
  always_comb begin
    err_byte = bcrp_pkg::ERR_OK;
    unique case (e_phase)
      bcrp_pkg::PH_VALID: begin
        if (e_pos == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_VALIDATION) begin
          err_byte = bcrp_pkg::ERR_BAD_ID;
        end
      end
      bcrp_pkg::PH_HDR_FIRST, bcrp_pkg::PH_HDR_NEXT: begin
        if (e_pos == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_HDR_MORE
            && b != bcrp_pkg::ID_HDR_LAST) begin
          err_byte = bcrp_pkg::ERR_BAD_ID;
        end
      end
      bcrp_pkg::PH_DEFAULT, bcrp_pkg::PH_ENTRY: begin
        priority if (e_pos == bcrp_pkg::POS_ID && b != bcrp_pkg::BOOT_MARK
                     && b != bcrp_pkg::BYTE_ZERO) begin
          err_byte = bcrp_pkg::ERR_BOOT_IND;
        end else if (e_pos == bcrp_pkg::POS_PLATFORM
                     && b[3:0] > bcrp_pkg::MEDIA_MAX) begin
          err_byte = bcrp_pkg::ERR_MEDIA;
        end else if (e_pos == bcrp_pkg::POS_CRIT && e_phase == bcrp_pkg::PH_ENTRY
                     && b > bcrp_pkg::CRIT_MAX) begin
          err_byte = bcrp_pkg::ERR_CRITERIA;
        end else begin
        end
      end
      bcrp_pkg::PH_EXT: begin
        if (e_pos == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_EXTENSION) begin
          err_byte = bcrp_pkg::ERR_BAD_ID;
        end
      end
      default: begin
      end
    endcase
  end

  // First fault wins; checksum is judged at the last byte
  always_comb begin
    err_final = (e_err != bcrp_pkg::ERR_OK) ? e_err : err_byte;
    if (err_final == bcrp_pkg::ERR_OK && rec_done && e_phase == bcrp_pkg::PH_VALID
        && sum_now != 16'd0) begin
      err_final = bcrp_pkg::ERR_CHECKSUM;
    end
  end

  // Kind of the record being completed
  always_comb begin
    unique case (e_phase)
      bcrp_pkg::PH_VALID:     kind = bcrp_pkg::KIND_VALIDATION;
      bcrp_pkg::PH_DEFAULT:   kind = bcrp_pkg::KIND_DEFAULT;
      bcrp_pkg::PH_HDR_FIRST,
      bcrp_pkg::PH_HDR_NEXT:  kind = bcrp_pkg::KIND_HEADER;
      bcrp_pkg::PH_ENTRY:     kind = bcrp_pkg::KIND_ENTRY;
      default:                kind = bcrp_pkg::KIND_EXTENSION;
    endcase
  end

  assign hdr_count = {record_bytes[3], record_bytes[2]};
  assign ent_dec   = e_entries - {15'd0, (e_entries != 16'd0)};
  assign ext_more  = record_bytes[1][bcrp_pkg::EXT_MORE_BIT];

  // Entry count and last-header flag that decide what follows a chain
  always_comb begin
    if (kind == bcrp_pkg::KIND_HEADER) begin
      chain_entries = hdr_count;
      chain_last    = (record_bytes[0] == bcrp_pkg::ID_HDR_LAST);
    end else if (kind == bcrp_pkg::KIND_ENTRY) begin
      chain_entries = ent_dec;
      chain_last    = e_last;
    end else begin
      chain_entries = e_entries;
      chain_last    = e_last;
    end
  end

  // Next state of the walk
  always_comb begin
    byte_position_next    = byte_position;
    record_phase_next     = record_phase;
    word_sum_next         = word_sum;
    held_low_byte_next    = held_low_byte;
    current_platform_next = current_platform;
    entries_left_next     = entries_left;
    last_header_seen_next = last_header_seen;
    pending_error_next    = pending_error;
    finished_flag_next    = finished_flag;
    if (active) begin
      record_phase_next     = e_phase;
      entries_left_next     = e_entries;
      last_header_seen_next = e_last;
      finished_flag_next    = 1'b0;
      held_low_byte_next    = e_pos[0] ? e_held : b;
      word_sum_next         = sum_now;
      pending_error_next    = err_final;
      byte_position_next    = e_pos + 5'd1;
      current_platform_next = e_plat;
      if (e_pos == bcrp_pkg::POS_PLATFORM && (e_phase == bcrp_pkg::PH_VALID
          || e_phase == bcrp_pkg::PH_HDR_FIRST || e_phase == bcrp_pkg::PH_HDR_NEXT)) begin
        current_platform_next = b;
      end
      priority if (end_mark) begin
        finished_flag_next = 1'b1;
      end else if (rec_done) begin
        byte_position_next = 5'd0;
        word_sum_next      = 16'd0;
        pending_error_next = bcrp_pkg::ERR_OK;
        if (err_final != bcrp_pkg::ERR_OK) begin
          finished_flag_next = 1'b1;
        end else begin
          if (kind == bcrp_pkg::KIND_HEADER) begin
            entries_left_next     = hdr_count;
            last_header_seen_next = chain_last;
          end else if (kind == bcrp_pkg::KIND_ENTRY) begin
            entries_left_next = ent_dec;
          end
          priority if (kind == bcrp_pkg::KIND_VALIDATION) begin
            record_phase_next = bcrp_pkg::PH_DEFAULT;
          end else if (kind == bcrp_pkg::KIND_DEFAULT) begin
            record_phase_next = bcrp_pkg::PH_HDR_FIRST;
          end else if (kind != bcrp_pkg::KIND_HEADER && ext_more) begin
            record_phase_next = bcrp_pkg::PH_EXT;
          end else if (chain_entries != 16'd0) begin
            record_phase_next = bcrp_pkg::PH_ENTRY;
          end else if (chain_last) begin
            finished_flag_next = 1'b1;
          end else begin
            record_phase_next = bcrp_pkg::PH_HDR_NEXT;
          end
        end
      end else begin
      end
    end
  end

  // Result fields
  always_comb begin
    res      = '0;
    seg      = hdr_count;
    res_push = active && (end_mark || rec_done);
    if (seg == 16'd0) begin
      seg = bcrp_pkg::SEG_DEFAULT;
    end
    res.platform      = e_plat;
    res.walk_finished = finished_flag_next;
    if (end_mark) begin
      res.record_kind = bcrp_pkg::KIND_END;
    end else begin
      res.record_kind = kind;
      res.error_code  = err_final;
      if (kind == bcrp_pkg::KIND_DEFAULT || kind == bcrp_pkg::KIND_ENTRY) begin
        res.bootable     = (record_bytes[0] == bcrp_pkg::BOOT_MARK);
        res.media_type   = record_bytes[1][3:0];
        res.load_value   = (e_plat == bcrp_pkg::BYTE_ZERO) ? {4'd0, seg}
                           : {record_bytes[2], record_bytes[3], 4'd0};
        res.sector_count = {record_bytes[7], record_bytes[6]};
        res.start_block  = {record_bytes[11], record_bytes[10],
                            record_bytes[9], record_bytes[8]};
      end else if (kind == bcrp_pkg::KIND_HEADER) begin
        res.section_count = hdr_count;
        res.last_flag     = (record_bytes[0] == bcrp_pkg::ID_HDR_LAST);
      end else if (kind == bcrp_pkg::KIND_EXTENSION) begin
        res.last_flag = !ext_more;
      end
    end
  end

  // Walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 5'd0;
      record_phase     <= bcrp_pkg::PH_VALID;
      word_sum         <= 16'd0;
      held_low_byte    <= 8'd0;
      current_platform <= 8'd0;
      entries_left     <= 16'd0;
      last_header_seen <= 1'b0;
      pending_error    <= bcrp_pkg::ERR_OK;
      finished_flag    <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      record_phase     <= record_phase_next;
      word_sum         <= word_sum_next;
      held_low_byte    <= held_low_byte_next;
      current_platform <= current_platform_next;
      entries_left     <= entries_left_next;
      last_header_seen <= last_header_seen_next;
      pending_error    <= pending_error_next;
      finished_flag    <= finished_flag_next;
    end
  end

  // Capture of bytes 0..11 for decode at the record end
  always_ff @(posedge clk) begin
    if (active && e_pos < 5'(bcrp_pkg::REC_KEPT)) begin
      record_bytes[e_pos[bcrp_pkg::KEPT_W-1:0]] <= b;
    end
  end

  bcrp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .full      (queue_full),
    .records   (records)
  );

  // Checks
  `ASSERT_IMPLIES(a_quiet_when_done, finished_flag && !(accept && restart), !res_push,
    "result produced after the walk ended")
  `ASSERT_NEXT(a_finish_sticks, res_push && res.walk_finished, finished_flag,
    "walk_finished reported but walk still running")
  `ASSERT_IMPLIES(a_entry_has_count,
    record_phase == bcrp_pkg::PH_ENTRY && !finished_flag, entries_left != 16'd0,
    "section entry expected with no entries left")
  `ASSERT_IMPLIES(a_stall_only_full, !catalog.ready, records.valid,
    "byte side stalled with no result pending")

endmodule

// File: bench/tb_boot_catalog_record_parser.sv
module tb_boot_catalog_record_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // One 32-byte catalog record, byte i at index i
  typedef logic [31:0][7:0] rec_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_STARVE,
    RX_CADENCE
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  bcrp_stream_if #(.payload_t(bcrp_pkg::catalog_item_t)) catalog_ch ();
  bcrp_stream_if #(.payload_t(bcrp_pkg::record_item_t))  record_ch ();

  boot_catalog_record_parser uut (
    .clk     (clk),
    .rst     (rst),
    .catalog (catalog_ch),
    .records (record_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("boot_catalog_record_parser: mismatch");
    $finish;
  end

  // Walk state of the predictor
  logic [4:0]                          w_pos;
  bcrp_pkg::phase_t                    w_phase;
  logic [15:0]                         w_sum;
  logic [7:0]                          w_held;
  logic [7:0]                          w_platform;
  logic [15:0]                         w_entries;
  logic                                w_last_hdr;
  logic                                w_ext;
  logic [bcrp_pkg::REC_KEPT-1:0][7:0]  w_rec;
  logic [2:0]                          w_err;
  logic                                w_done;

  bcrp_pkg::record_item_t expected_records[$];
  bcrp_pkg::record_item_t want_rec;
  int           mismatches = 0;
  int           walk_bytes = 0;
  int           burst_left = 0;
  int unsigned  stall_tick = 0;
  rx_mode_t     stall_mode = RX_OPEN;

  function automatic void clear_walk();
    w_pos      = '0;
    w_phase    = bcrp_pkg::PH_VALID;
    w_sum      = '0;
    w_held     = '0;
    w_platform = '0;
    w_entries  = '0;
    w_last_hdr = 1'b0;
    w_ext      = 1'b0;
    w_rec      = '0;
    w_err      = bcrp_pkg::ERR_OK;
    w_done     = 1'b0;
  endfunction

  // First fault in byte order wins
  function automatic void flag_fault(input logic [2:0] code);
    if (w_err == bcrp_pkg::ERR_OK) w_err = code;
  endfunction

  // Where the walk goes once an entry and its extensions are done
  function automatic void close_entry_chain();
    if (w_entries != 16'd0) w_phase = bcrp_pkg::PH_ENTRY;
    else if (w_last_hdr) w_done = 1'b1;
    else w_phase = bcrp_pkg::PH_HDR_NEXT;
  endfunction

  // Advance the walk by one catalog byte; returns 1 when a record result is due
  function automatic bit step_catalog_walk(input logic [7:0] b, input logic sof,
                                           output bcrp_pkg::record_item_t res);
    logic [4:0]  p;
    logic [2:0]  kind;
    logic [15:0] seg;
    res = '0;
    if (sof) clear_walk();
    else if (w_done) return 1'b0;

    p = w_pos;
    if (p < bcrp_pkg::REC_KEPT) w_rec[p] = b;
    if (!p[0]) w_held = b;
    else w_sum = w_sum + {b, w_held};

    // zero byte where a header would start ends the catalog
    if (w_phase == bcrp_pkg::PH_HDR_FIRST && p == bcrp_pkg::POS_ID
        && b == bcrp_pkg::BYTE_ZERO) begin
      w_done = 1'b1;
      res.record_kind = bcrp_pkg::KIND_END;
      res.platform = w_platform;
      res.walk_finished = 1'b1;
      return 1'b1;
    end

    case (w_phase)
      bcrp_pkg::PH_VALID: begin
        if (p == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_VALIDATION)
          flag_fault(bcrp_pkg::ERR_BAD_ID);
        if (p == bcrp_pkg::POS_PLATFORM) w_platform = b;
      end
      bcrp_pkg::PH_HDR_FIRST, bcrp_pkg::PH_HDR_NEXT: begin
        if (p == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_HDR_MORE
            && b != bcrp_pkg::ID_HDR_LAST)
          flag_fault(bcrp_pkg::ERR_BAD_ID);
        if (p == bcrp_pkg::POS_PLATFORM) w_platform = b;
      end
      bcrp_pkg::PH_DEFAULT, bcrp_pkg::PH_ENTRY: begin
        if (p == bcrp_pkg::POS_ID && b != bcrp_pkg::BOOT_MARK && b != bcrp_pkg::BYTE_ZERO)
          flag_fault(bcrp_pkg::ERR_BOOT_IND);
        if (p == bcrp_pkg::POS_PLATFORM && b[3:0] > bcrp_pkg::MEDIA_MAX)
          flag_fault(bcrp_pkg::ERR_MEDIA);
        if (p == bcrp_pkg::POS_CRIT && w_phase == bcrp_pkg::PH_ENTRY
            && b != bcrp_pkg::BYTE_ZERO && b != bcrp_pkg::CRIT_MAX)
          flag_fault(bcrp_pkg::ERR_CRITERIA);
      end
      default: begin
        if (p == bcrp_pkg::POS_ID && b != bcrp_pkg::ID_EXTENSION)
          flag_fault(bcrp_pkg::ERR_BAD_ID);
      end
    endcase

    if (p != bcrp_pkg::POS_LAST) begin
      w_pos = p + 5'd1;
      return 1'b0;
    end
    w_pos = '0;
    if (w_phase == bcrp_pkg::PH_VALID && w_sum != 16'd0) flag_fault(bcrp_pkg::ERR_CHECKSUM);

    case (w_phase)
      bcrp_pkg::PH_VALID:     kind = bcrp_pkg::KIND_VALIDATION;
      bcrp_pkg::PH_DEFAULT:   kind = bcrp_pkg::KIND_DEFAULT;
      bcrp_pkg::PH_HDR_FIRST,
      bcrp_pkg::PH_HDR_NEXT:  kind = bcrp_pkg::KIND_HEADER;
      bcrp_pkg::PH_ENTRY:     kind = bcrp_pkg::KIND_ENTRY;
      default:                kind = bcrp_pkg::KIND_EXTENSION;
    endcase
    res.record_kind = kind;
    res.error_code  = w_err;
    res.platform    = w_platform;

    if (kind == bcrp_pkg::KIND_DEFAULT || kind == bcrp_pkg::KIND_ENTRY) begin
      res.bootable   = (w_rec[0] == bcrp_pkg::BOOT_MARK);
      res.media_type = w_rec[1][3:0];
      // x86 takes a load segment, others a shifted address
      if (w_platform == bcrp_pkg::BYTE_ZERO) begin
        seg = {w_rec[3], w_rec[2]};
        if (seg == 16'd0) seg = bcrp_pkg::SEG_DEFAULT;
        res.load_value = {4'h0, seg};
      end else begin
        res.load_value = {w_rec[2], w_rec[3], 4'h0};
      end
      res.sector_count = {w_rec[7], w_rec[6]};
      res.start_block  = {w_rec[11], w_rec[10], w_rec[9], w_rec[8]};
    end else if (kind == bcrp_pkg::KIND_HEADER) begin
      res.section_count = {w_rec[3], w_rec[2]};
      res.last_flag     = (w_rec[0] == bcrp_pkg::ID_HDR_LAST);
    end else if (kind == bcrp_pkg::KIND_EXTENSION) begin
      res.last_flag = !w_rec[1][bcrp_pkg::EXT_MORE_BIT];
    end

    // next phase of the walk
    if (w_err != bcrp_pkg::ERR_OK) begin
      w_done = 1'b1;
    end else begin
      case (kind)
        bcrp_pkg::KIND_VALIDATION: w_phase = bcrp_pkg::PH_DEFAULT;
        bcrp_pkg::KIND_DEFAULT:    w_phase = bcrp_pkg::PH_HDR_FIRST;
        bcrp_pkg::KIND_HEADER: begin
          w_entries  = {w_rec[3], w_rec[2]};
          w_last_hdr = (w_rec[0] == bcrp_pkg::ID_HDR_LAST);
          close_entry_chain();
        end
        bcrp_pkg::KIND_ENTRY: begin
          if (w_entries != 16'd0) w_entries = w_entries - 16'd1;
          w_ext = w_rec[1][bcrp_pkg::EXT_MORE_BIT];
          if (w_ext) w_phase = bcrp_pkg::PH_EXT;
          else close_entry_chain();
        end
        default: begin
          w_ext = w_rec[1][bcrp_pkg::EXT_MORE_BIT];
          if (!w_ext) close_entry_chain();
        end
      endcase
    end

    w_sum = '0;
    w_err = bcrp_pkg::ERR_OK;
    res.walk_finished = w_done;
    return 1'b1;
  endfunction

  // Record builders; filler bytes are random
  function automatic rec_t random_record();
    rec_t r;
    for (int i = 0; i < 32; i++) r[i] = 8'($urandom);
    return r;
  endfunction

  function automatic rec_t build_validation(input logic [7:0] plat);
    rec_t        r;
    logic [15:0] acc;
    r = random_record();
    r[0] = bcrp_pkg::ID_VALIDATION;
    r[1] = plat;
    r[30] = 8'h55;
    r[31] = 8'hAA;
    // word 14 balances the little-endian word sum to zero
    acc = '0;
    for (int i = 0; i < 16; i++)
      if (i != 14) acc = acc + {r[2*i+1], r[2*i]};
    acc = -acc;
    r[28] = acc[7:0];
    r[29] = acc[15:8];
    return r;
  endfunction

  function automatic rec_t build_entry(input bit chain);
    rec_t r;
    r = random_record();
    r[0] = $urandom_range(0, 1) ? bcrp_pkg::BOOT_MARK : bcrp_pkg::BYTE_ZERO;
    r[1] = {r[1][7:6], chain, r[1][4], 4'($urandom_range(0, bcrp_pkg::MEDIA_MAX))};
    r[12] = $urandom_range(0, 1) ? bcrp_pkg::CRIT_MAX : bcrp_pkg::BYTE_ZERO;
    if ($urandom_range(0, 3) == 0) begin
      r[2] = bcrp_pkg::BYTE_ZERO;
      r[3] = bcrp_pkg::BYTE_ZERO;
    end
    return r;
  endfunction

  function automatic rec_t build_header(input logic [7:0] id, input logic [7:0] plat,
                                        input logic [15:0] count);
    rec_t r;
    r = random_record();
    r[0] = id;
    r[1] = plat;
    r[2] = count[7:0];
    r[3] = count[15:8];
    return r;
  endfunction

  function automatic rec_t build_extension(input bit more);
    rec_t r;
    r = random_record();
    r[0] = bcrp_pkg::ID_EXTENSION;
    r[1][bcrp_pkg::EXT_MORE_BIT] = more;
    return r;
  endfunction

  function automatic logic [7:0] pick_platform();
    case ($urandom_range(0, 3))
      0:       return bcrp_pkg::BYTE_ZERO;
      1:       return 8'h01;
      2:       return 8'hEF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one catalog byte; predict at the transfer, then maybe pause
  task automatic send_byte(input logic [7:0] b, input logic sof);
    bcrp_pkg::record_item_t res;
    bit                     counts;
    catalog_ch.valid <= 1'b1;
    catalog_ch.data  <= '{catalog_byte: b, start_of_catalog: sof};
    @(posedge clk);
    while (!catalog_ch.ready) @(posedge clk);
    counts = sof || !w_done;
    if (step_catalog_walk(b, sof, res)) begin
      expected_records.push_back(res);
    end
    if (counts) walk_bytes++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      catalog_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(0, 24);
    end
  endtask

  task automatic send_record(input rec_t r, input logic sof, input int len);
    for (int i = 0; i < len; i++) send_byte(r[i], (i == 0) ? sof : 1'b0);
  endtask

  // Bytes after the walk has ended; the block drops them
  task automatic send_tail();
    repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
  endtask

  // Random walk record: sometimes faulty, sometimes cut short
  task automatic emit_record(input rec_t r, input logic sof, output bit stop);
    int len;
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 3))
        0:       r[0] = 8'($urandom);
        1:       r[1] = 8'($urandom);
        2:       r[12] = 8'($urandom);
        default: r[28] = r[28] ^ 8'($urandom_range(1, 255));
      endcase
    end
    len = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 31) : 32;
    send_record(r, sof, len);
    stop = (len != 32) || w_done;
    if (w_done) send_tail();
  endtask

  // Catalog with no start mark right after reset, ended by a zero byte
  task automatic test_unmarked_start();
    rec_t r;
    send_record(build_validation(bcrp_pkg::BYTE_ZERO), 1'b0, 32);
    r = build_entry(1'b0);
    r[0] = bcrp_pkg::BOOT_MARK;
    r[1] = 8'h02;
    r[2] = bcrp_pkg::BYTE_ZERO;
    r[3] = bcrp_pkg::BYTE_ZERO;
    send_record(r, 1'b0, 32);
    send_byte(bcrp_pkg::BYTE_ZERO, 1'b0);
    send_tail();
  endtask

  task automatic test_validation_faults();
    rec_t r;
    // wrong id also breaks the sum; id is reported
    r = build_validation(8'h01);
    r[0] = 8'hFE;
    send_record(r, 1'b1, 32);
    send_tail();
    r = build_validation(8'h02);
    r[28] = r[28] ^ 8'h01;
    send_record(r, 1'b1, 32);
    send_tail();
  endtask

  task automatic test_entry_faults();
    rec_t r;
    // bad boot indicator in the default entry
    send_record(build_validation(8'hFF), 1'b1, 32);
    r = build_entry(1'b0);
    r[0] = 8'h23;
    send_record(r, 1'b0, 32);
    send_tail();
    // media nibble out of range
    send_record(build_validation(bcrp_pkg::BYTE_ZERO), 1'b1, 32);
    r = build_entry(1'b0);
    r[1] = 8'hFF;
    send_record(r, 1'b0, 32);
    // criteria ignored in the default entry, checked in a section entry
    send_record(build_validation(8'hEF), 1'b1, 32);
    r = build_entry(1'b0);
    r[12] = 8'hFF;
    send_record(r, 1'b0, 32);
    send_record(build_header(bcrp_pkg::ID_HDR_LAST, 8'hEF, 16'd1), 1'b0, 32);
    r = build_entry(1'b0);
    r[12] = 8'h02;
    send_record(r, 1'b0, 32);
    // header with a bad id
    send_record(build_validation(bcrp_pkg::BYTE_ZERO), 1'b1, 32);
    send_record(build_entry(1'b0), 1'b0, 32);
    send_record(build_header(8'h55, bcrp_pkg::BYTE_ZERO, 16'd1), 1'b0, 32);
    send_tail();
  endtask

  task automatic test_sections();
    rec_t r;
    send_record(build_validation(bcrp_pkg::BYTE_ZERO), 1'b1, 32);
    send_record(build_entry(1'b0), 1'b0, 32);
    // empty non-last header, then one entry with a two-long extension chain
    send_record(build_header(bcrp_pkg::ID_HDR_MORE, bcrp_pkg::BYTE_ZERO, 16'd0), 1'b0, 32);
    send_record(build_header(bcrp_pkg::ID_HDR_MORE, 8'hEF, 16'd1), 1'b0, 32);
    r = build_entry(1'b1);
    for (int i = 2; i < 12; i++) r[i] = 8'hFF;
    send_record(r, 1'b0, 32);
    send_record(build_extension(1'b1), 1'b0, 32);
    send_record(build_extension(1'b0), 1'b0, 32);
    // last header: x86 segments at both extremes
    send_record(build_header(bcrp_pkg::ID_HDR_LAST, bcrp_pkg::BYTE_ZERO, 16'd2), 1'b0, 32);
    r = build_entry(1'b0);
    r[2] = 8'hFF;
    r[3] = 8'hFF;
    send_record(r, 1'b0, 32);
    r = build_entry(1'b0);
    for (int i = 2; i < 12; i++) r[i] = bcrp_pkg::BYTE_ZERO;
    send_record(r, 1'b0, 32);
    send_tail();
    // empty last header ends the walk
    send_record(build_validation(8'h01), 1'b1, 32);
    send_record(build_entry(1'b0), 1'b0, 32);
    send_record(build_header(bcrp_pkg::ID_HDR_LAST, 8'h02, 16'd0), 1'b0, 32);
    send_tail();
    // extension with a bad id
    send_record(build_validation(8'h01), 1'b1, 32);
    send_record(build_entry(1'b0), 1'b0, 32);
    send_record(build_header(bcrp_pkg::ID_HDR_LAST, 8'h01, 16'd1), 1'b0, 32);
    send_record(build_entry(1'b1), 1'b0, 32);
    r = build_extension(1'b0);
    r[0] = 8'h45;
    send_record(r, 1'b0, 32);
    send_tail();
  endtask

  // Start mark in the middle of a record restarts the walk
  task automatic test_restart();
    send_record(build_validation(bcrp_pkg::BYTE_ZERO), 1'b1, 32);
    send_record(build_entry(1'b0), 1'b0, 32);
    send_record(build_header(bcrp_pkg::ID_HDR_MORE, bcrp_pkg::BYTE_ZERO, 16'd1), 1'b0, 10);
    send_record(build_validation(8'h01), 1'b1, 20);
    send_record(build_validation(8'hEF), 1'b1, 32);
    send_record(build_entry(1'b1), 1'b0, 32);
    send_byte(bcrp_pkg::BYTE_ZERO, 1'b0);
    send_tail();
  endtask

  // Well-formed catalog with random content, faults and cut-offs
  task automatic send_random_catalog();
    bit          stop;
    bit          chain;
    int          n_hdr;
    int          n_ent;
    logic [15:0] count;
    emit_record(build_validation(pick_platform()), 1'b1, stop);
    if (stop) return;
    emit_record(build_entry(1'($urandom_range(0, 1))), 1'b0, stop);
    if (stop) return;
    if ($urandom_range(0, 5) == 0) begin
      send_byte(bcrp_pkg::BYTE_ZERO, 1'b0);
      send_tail();
      return;
    end
    n_hdr = $urandom_range(1, 3);
    for (int h = 0; h < n_hdr; h++) begin
      count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      emit_record(build_header((h == n_hdr - 1) ? bcrp_pkg::ID_HDR_LAST
                                                : bcrp_pkg::ID_HDR_MORE,
                               pick_platform(), count), 1'b0, stop);
      if (stop) return;
      n_ent = (count > 16'd3) ? 3 : int'(count);
      for (int e = 0; e < n_ent; e++) begin
        chain = ($urandom_range(0, 3) == 0);
        emit_record(build_entry(chain), 1'b0, stop);
        if (stop) return;
        while (chain) begin
          chain = ($urandom_range(0, 2) == 0);
          emit_record(build_extension(chain), 1'b0, stop);
          if (stop) return;
        end
      end
      // a huge count leaves the walk open; the next start mark cuts it
      if (count > 16'd3) return;
    end
  endtask

  task automatic test_random_walks();
    int first_bytes;
    first_bytes = walk_bytes;
    while (walk_bytes - first_bytes < 300) begin
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(8, 48))
          send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      else
        send_random_catalog();
    end
  endtask

  // Receiver: stall pattern switches when the low byte of stall_tick wraps
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[7:0] == 8'hFF) stall_mode <= rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_OPEN:    record_ch.ready <= 1'b1;
      RX_RANDOM:  record_ch.ready <= 1'($urandom_range(0, 1));
      RX_STARVE:  record_ch.ready <= (stall_tick[6:0] == 7'd0);
      default:    record_ch.ready <= (stall_tick % 3 != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && record_ch.valid && record_ch.ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: result with none expected, actual 0x%0h", $time, record_ch.data);
        mismatches++;
      end else begin
        want_rec = expected_records.pop_front();
        check_field("record_kind", want_rec.record_kind, record_ch.data.record_kind);
        check_field("error_code", want_rec.error_code, record_ch.data.error_code);
        check_field("platform", want_rec.platform, record_ch.data.platform);
        check_field("bootable", want_rec.bootable, record_ch.data.bootable);
        check_field("media_type", want_rec.media_type, record_ch.data.media_type);
        check_field("load_value", want_rec.load_value, record_ch.data.load_value);
        check_field("sector_count", want_rec.sector_count, record_ch.data.sector_count);
        check_field("start_block", want_rec.start_block, record_ch.data.start_block);
        check_field("section_count", want_rec.section_count,
                    record_ch.data.section_count);
        check_field("last_flag", want_rec.last_flag, record_ch.data.last_flag);
        check_field("walk_finished", want_rec.walk_finished,
                    record_ch.data.walk_finished);
      end
    end
  end

  initial begin
    rst = 1'b1;
    catalog_ch.valid = 1'b0;
    catalog_ch.data = '0;
    record_ch.ready = 1'b0;
    clear_walk();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_unmarked_start();
    test_validation_faults();
    test_entry_faults();
    test_sections();
    test_restart();
    test_random_walks();

    catalog_ch.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_records.size() == 0)
      $display("boot_catalog_record_parser: match");
    else
      $display("boot_catalog_record_parser: mismatch");
    $finish;
  end

endmodule
